// File: rtl/lpae_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the stereo DPCM encoder.
// No dependencies; lpae_front, lpae_back and the top level import this package.
package lpae_pkg;

	// Field widths
	localparam int SAMPLE_BITS = 16;
	localparam int RES_BITS    = 20;
	localparam int HIST_BITS   = 20;
	localparam int SHIFT_BITS  = 4;
	localparam int MODE_BITS   = 2;
	localparam int CHAN_BITS   = SAMPLE_BITS + 1;  // mid/side need one extra bit
	localparam int CALC_BITS   = 40;               // holds pred, diff and r << 15

	// Queue depths
	localparam int LPAE_QUEUE_DEPTH  = 2;
	localparam int LPAE_RESULT_DEPTH = 2;

	// Configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_SHIFT = 1'b1;

	// Coding modes (the unused code behaves as first order)
	localparam logic [MODE_BITS-1:0] MODE_FIRST   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_POLY    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_MIDSIDE = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic                          restart;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_BITS-1:0] residual_a;
		logic signed [RES_BITS-1:0] residual_b;
	} result_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic                        poly;
		logic                        restart;
		logic signed [CHAN_BITS-1:0] chan_a;
		logic signed [CHAN_BITS-1:0] chan_b;
	} queue_entry_t;

endpackage

// File: rtl/lpae_fifo.sv
`timescale 1ns / 1ps
// Small register-based FIFO used between front and back and on the result side.
// Depends on nothing; generic width and depth (depth at least 2).
module lpae_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fifo occupancy above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("fifo count did not advance on write");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("fifo count did not drop on read");

endmodule

// File: rtl/lpae_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions and classifies them for the back end
// (mid/side split, predictor select). Depends on lpae_pkg.
module lpae_front import lpae_pkg::*; (
	input  logic                 push,
	input  in_item_t             item,
	input  logic [MODE_BITS-1:0] mode,
	input  logic                 q_full,
	output logic                 q_wr,
	output queue_entry_t         q_entry
);

	logic signed [CHAN_BITS-1:0] left_x, right_x, sum, mid, side;

	assign q_wr = push && !q_full;

	// Sign-extend, then mid = (l+r)/2 toward zero, side = l-r
	always_comb begin
		left_x  = CHAN_BITS'(item.left_sample);
		right_x = CHAN_BITS'(item.right_sample);
		sum     = left_x + right_x;
		mid     = (sum + $signed(CHAN_BITS'(sum[CHAN_BITS-1]))) >>> 1;
		side    = left_x - right_x;

		q_entry.poly    = (mode == MODE_POLY);
		q_entry.restart = item.restart;
		if (mode == MODE_MIDSIDE) begin
			q_entry.chan_a = mid;
			q_entry.chan_b = side;
		end else begin
			q_entry.chan_a = left_x;
			q_entry.chan_b = right_x;
		end
	end

endmodule

// File: rtl/lpae_back.sv
`timescale 1ns / 1ps
// Back end: closed-loop prediction, quantization and reconstruction for both
// channels, one transaction per cycle when the queues allow. Depends on lpae_pkg.
module lpae_back import lpae_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SHIFT_BITS-1:0] shift,
	input  logic                  q_empty,
	input  queue_entry_t          q_entry,
	output logic                  q_rd,
	input  logic                  out_full,
	output logic                  out_wr,
	output result_t               out_item
);

	typedef struct packed {
		logic signed [RES_BITS-1:0]  res;
		logic signed [HIST_BITS-1:0] rec;
	} chan_out_t;

	localparam logic signed [CALC_BITS-1:0] RES_HI  = CALC_BITS'(2 ** (RES_BITS - 1) - 1);
	localparam logic signed [CALC_BITS-1:0] RES_LO  = -RES_HI - 1;
	localparam logic signed [CALC_BITS-1:0] HIST_HI = CALC_BITS'(2 ** (HIST_BITS - 1) - 1);
	localparam logic signed [CALC_BITS-1:0] HIST_LO = -HIST_HI - 1;

	function automatic logic signed [RES_BITS-1:0] sat_res(
		input logic signed [CALC_BITS-1:0] v);
		if (v > RES_HI) begin
			return RES_BITS'(RES_HI);
		end else if (v < RES_LO) begin
			return RES_BITS'(RES_LO);
		end
		return RES_BITS'(v);
	endfunction

	function automatic logic signed [HIST_BITS-1:0] sat_hist(
		input logic signed [CALC_BITS-1:0] v);
		if (v > HIST_HI) begin
			return HIST_BITS'(HIST_HI);
		end else if (v < HIST_LO) begin
			return HIST_BITS'(HIST_LO);
		end
		return HIST_BITS'(v);
	endfunction

	// One channel: predict, quantize with floor shift, rebuild what a decoder sees
	function automatic chan_out_t code_chan(
		input logic                        poly,
		input logic [1:0]                  wc,
		input logic signed [HIST_BITS-1:0] h0,
		input logic signed [HIST_BITS-1:0] h1,
		input logic signed [HIST_BITS-1:0] h2,
		input logic signed [CHAN_BITS-1:0] x,
		input logic [SHIFT_BITS-1:0]       k);
		logic signed [CALC_BITS-1:0] a, b, c, xx, pred, diff, rx, rec;
		chan_out_t o;
		a  = CALC_BITS'(h0);
		b  = CALC_BITS'(h1);
		c  = CALC_BITS'(h2);
		xx = CALC_BITS'(x);
		if (poly) begin
			case (wc)
				2'd0:    pred = '0;
				2'd1:    pred = a;
				2'd2:    pred = (a <<< 1) - b;
				default: pred = (a <<< 1) + a - ((b <<< 1) + b) + c;
			endcase
			diff = pred - xx;
		end else begin
			pred = a;
			diff = xx - pred;
		end
		o.res = sat_res(diff >>> k);
		rx    = CALC_BITS'(o.res) <<< k;
		rec   = poly ? pred - rx : pred + rx;
		o.rec = sat_hist(rec);
		return o;
	endfunction

	logic signed [HIST_BITS-1:0] hist_a_q [3];
	logic signed [HIST_BITS-1:0] hist_b_q [3];
	logic signed [HIST_BITS-1:0] ha [3];
	logic signed [HIST_BITS-1:0] hb [3];
	logic [1:0]                  wc_q, wc_eff;
	logic                        fire;
	chan_out_t                   ca, cb;

	assign fire   = !q_empty && !out_full;
	assign q_rd   = fire;
	assign out_wr = fire;

	// Restart clears history and warm-up for this transaction
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ha[i] = q_entry.restart ? '0 : hist_a_q[i];
			hb[i] = q_entry.restart ? '0 : hist_b_q[i];
		end
		wc_eff = q_entry.restart ? 2'd0 : wc_q;
		ca = code_chan(q_entry.poly, wc_eff, ha[0], ha[1], ha[2], q_entry.chan_a, shift);
		cb = code_chan(q_entry.poly, wc_eff, hb[0], hb[1], hb[2], q_entry.chan_b, shift);
		out_item.residual_a = ca.res;
		out_item.residual_b = cb.res;
	end

	// History shift line and saturating warm-up counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				hist_a_q[i] <= '0;
				hist_b_q[i] <= '0;
			end
			wc_q <= '0;
		end else if (fire) begin
			hist_a_q[0] <= ca.rec;
			hist_a_q[1] <= ha[0];
			hist_a_q[2] <= ha[1];
			hist_b_q[0] <= cb.rec;
			hist_b_q[1] <= hb[0];
			hist_b_q[2] <= hb[1];
			wc_q        <= (wc_eff == 2'd3) ? 2'd3 : wc_eff + 2'd1;
		end
	end

	a_restart_warm: assert property (@(posedge clk) disable iff (!arst_n)
		fire && q_entry.restart |=> wc_q == 2'd1)
		else $error("warm-up count not restarted");

	a_warm_sat: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !q_entry.restart && wc_q == 2'd3 |=> wc_q == 2'd3)
		else $error("warm-up count left saturation");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(wc_q) && $stable(hist_a_q[0]) && $stable(hist_b_q[0]))
		else $error("state changed without a transaction");

endmodule

// File: rtl/lossy_predictive_audio_encoder_top.sv
`timescale 1ns / 1ps
// Top level of the stereo closed-loop DPCM encoder: config registers, front end,
// decoupling queue, back end and result queue. Depends on lpae_pkg and all rtl modules.
//
// Takes one stereo sample pair per cycle while full is low, and returns one pair
// of quantized residuals per pair, in order. Sustained rate is one transaction
// per cycle while results are popped as they arrive; a result is registered in
// the input queue and then in the result queue before it shows on the output
// ports. The rate is set by the back end, which predicts, quantizes and rebuilds
// both channels combinationally, registering history for the next pair. A short
// queue separates the front end from the back end, and a result queue lets
// inputs keep flowing while results wait to be popped. Write mode and shift only
// while no transaction is in flight. There is no clearing pass after reset.
module lossy_predictive_audio_encoder_top import lpae_pkg::*; #(
	parameter int QUEUE_DEPTH  = LPAE_QUEUE_DEPTH,
	parameter int RESULT_DEPTH = LPAE_RESULT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input side
	input  logic                 push,
	output logic                 full,
	input  in_item_t             item,
	// result side
	input  logic                 pop,
	output logic                 empty,
	output result_t              result,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	logic [MODE_BITS-1:0]  mode_q;
	logic [SHIFT_BITS-1:0] shift_q;
	logic                  cfg_wr;
	logic                  q_wr, q_rd, q_full, q_empty;
	logic                  out_wr, out_full;
	queue_entry_t          q_in, q_out;
	result_t               out_item;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FIRST;
			shift_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MODE:  mode_q  <= pwdata[MODE_BITS-1:0];
				REG_SHIFT: shift_q <= pwdata[SHIFT_BITS-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE:  prdata = DATA_BITS'(mode_q);
			REG_SHIFT: prdata = DATA_BITS'(shift_q);
			default:   prdata = '0;
		endcase
	end

	assign full = q_full;

	lpae_front u_front (
		.push    (push),
		.item    (item),
		.mode    (mode_q),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_entry (q_in)
	);

	lpae_fifo #(
		.WIDTH ($bits(queue_entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_in),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_out),
		.empty   (q_empty)
	);

	lpae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (shift_q),
		.q_empty  (q_empty),
		.q_entry  (q_out),
		.q_rd     (q_rd),
		.out_full (out_full),
		.out_wr   (out_wr),
		.out_item (out_item)
	);

	lpae_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_results (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_item),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
